FILE: design/dcnf_pkg.sv
// Shared types, character codes and constants of the DIMACS CNF token parser.
package dcnf_pkg;

  // Fixed field widths of the result item.
  localparam int unsigned VIDX_W = 16;
  localparam int unsigned LINE_W = 24;
  localparam int unsigned KIND_W = 3;
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_D     = 8'h64;

  // Match position of the last character of the tag that follows a leading c on an independent-variable line.
  localparam logic [1:0] TAG_LAST = 2'd3;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LITERAL    = 3'd0,
    KIND_CLAUSE_END = 3'd1,
    KIND_INDEP      = 3'd2,
    KIND_ERROR      = 3'd3,
    KIND_DONE       = 3'd4
  } kind_e;

  // Parser modes, one-hot.
  typedef enum logic [6:0] {
    M_TOP      = 7'b0000001,
    M_SKIPLINE = 7'b0000010,
    M_TAG      = 7'b0000100,
    M_SKIP1    = 7'b0001000,
    M_CLAUSE   = 7'b0010000,
    M_INDEP    = 7'b0100000,
    M_FIN      = 7'b1000000
  } mode_e;

  // One result item.
  typedef struct packed {
    kind_e             kind;
    logic [VIDX_W-1:0] var_index;
    logic              negated;
    logic [LINE_W-1:0] error_line;
    logic              last;
  } res_t;

  // Up to two results written into the result buffer in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    res_t [1:0] item;
  } push_t;

  // Character of the tag at a given match position.
  function automatic logic [7:0] tag_char(logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_SPACE;
      2'd1:    ch = CH_I;
      2'd2:    ch = CH_N;
      default: ch = CH_D;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/dcnf_if.sv
// Valid/ready channel interfaces for the byte input and the token output.
interface dcnf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_input;

  modport source (output valid, output byte_value, output end_of_input, input ready);
  modport sink (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface dcnf_out_if;
  logic                         valid;
  logic                         ready;
  logic [dcnf_pkg::KIND_W-1:0]  kind;
  logic [dcnf_pkg::VIDX_W-1:0]  var_index;
  logic                         negated;
  logic [dcnf_pkg::LINE_W-1:0]  error_line;
  logic                         last;

  modport source (
    output valid, output kind, output var_index, output negated,
    output error_line, output last, input ready
  );
  modport sink (
    input valid, input kind, input var_index, input negated,
    input error_line, input last, output ready
  );
endinterface

FILE: design/dimacs_cnf_token_parser_core.sv
// Top level of the DIMACS CNF token parser: byte register, parser state and token output.
// The parser takes one text byte per cycle, when neither the result buffer nor the
// bitmap sweep holds it back, into an input register and handles it from there; a
// byte that causes two tokens (a number ended by a byte that itself closes or breaks
// the line) is the worst case, and a four-entry result buffer absorbs such bursts. After
// reset the bitmap of reported independent literals is swept clear, one variable per
// cycle, and no byte is taken until the sweep ends. The bitmap is read at the next value
// of the number being built, so its entry is ready when the number ends.
module dimacs_cnf_token_parser_core #(
  parameter int unsigned VAR_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcnf_in_if.sink       in_i,
  dcnf_out_if.source    out_o
);

  localparam int unsigned SumW = VAR_BITS + 4;

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eof_q;
  logic       accept;
  logic       process;

  // Parser state.
  dcnf_pkg::mode_e                mode_q, mode_d, mode_a;
  logic [VAR_BITS-1:0]            nv_q, nv_d;
  logic                           neg_q, neg_d;
  logic                           dig_q, dig_d;
  logic                           sgn_q, sgn_d;
  logic [1:0]                     tag_q, tag_d;
  logic [dcnf_pkg::LINE_W-1:0]    line_q, line_d;

  // Byte classes and arithmetic.
  logic                           is_space, is_digit, is_nl;
  logic [3:0]                     digit;
  logic [SumW-1:0]                nv_ext, sum;
  logic                           sum_ovf;
  logic [VAR_BITS+dcnf_pkg::VIDX_W-1:0] nv_wide;
  logic [dcnf_pkg::VIDX_W-1:0]    var_out;

  // Results and side effects.
  dcnf_pkg::res_t                 r_fin, r_dsp;
  logic                           fin_v, dsp_v, fin_done;
  dcnf_pkg::push_t                push;
  logic                           seen_we;
  logic [1:0]                     seen_rd, seen_wd;
  logic                           seen_busy;
  logic                           room;
  dcnf_pkg::res_t                 head;
  logic                           head_valid;

  // Input handshake: once the bitmap sweep is over, the register takes a byte when empty or being handled.
  assign process   = in_valid_q && room;
  assign in_i.ready = !seen_busy && (!in_valid_q || process);
  assign accept    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_i.byte_value;
      eof_q  <= in_i.end_of_input;
    end
  end

  // Byte classification and the multiply-by-ten accumulator.
  assign is_space = ((byte_q >= dcnf_pkg::CH_TAB) && (byte_q <= dcnf_pkg::CH_CR))
                    || (byte_q == dcnf_pkg::CH_SPACE);
  assign is_digit = (byte_q >= dcnf_pkg::CH_ZERO) && (byte_q <= dcnf_pkg::CH_NINE);
  assign is_nl    = (byte_q == dcnf_pkg::CH_NL);
  assign digit    = byte_q[3:0];
  assign nv_ext   = SumW'(nv_q);
  assign sum      = (nv_ext << 3) + (nv_ext << 1) + SumW'(digit);
  assign sum_ovf  = |sum[SumW-1:VAR_BITS];
  assign nv_wide  = {{dcnf_pkg::VIDX_W{1'b0}}, nv_q};
  assign var_out  = nv_wide[dcnf_pkg::VIDX_W-1:0];

  // Bitmap update for a newly reported independent literal.
  always_comb begin
    seen_wd        = seen_rd;
    seen_wd[neg_q] = 1'b1;
  end

  // Per-byte parse step: first end a number, then handle the byte in the new mode.
  always_comb begin
    mode_d   = mode_q;
    nv_d     = nv_q;
    neg_d    = neg_q;
    dig_d    = dig_q;
    sgn_d    = sgn_q;
    tag_d    = tag_q;
    line_d   = line_q;
    mode_a   = mode_q;
    fin_done = 1'b0;
    fin_v    = 1'b0;
    dsp_v    = 1'b0;
    seen_we  = 1'b0;
    r_fin    = '0;
    r_dsp    = '0;

    if (process) begin
      if (!eof_q && is_nl && (line_q != dcnf_pkg::LINE_MAX)) begin
        line_d = line_q + 1'b1;
      end

      // A number ends at the first byte that is not a digit.
      if (((mode_q == dcnf_pkg::M_CLAUSE) || (mode_q == dcnf_pkg::M_INDEP)) && dig_q
          && (eof_q || !is_digit)) begin
        fin_done = 1'b1;
        nv_d     = '0;
        neg_d    = 1'b0;
        dig_d    = 1'b0;
        sgn_d    = 1'b0;
        if (nv_q == '0) begin
          mode_a = dcnf_pkg::M_TOP;
          if (mode_q == dcnf_pkg::M_CLAUSE) begin
            fin_v      = 1'b1;
            r_fin.kind = dcnf_pkg::KIND_CLAUSE_END;
          end
        end else if (mode_q == dcnf_pkg::M_CLAUSE) begin
          fin_v           = 1'b1;
          r_fin.kind      = dcnf_pkg::KIND_LITERAL;
          r_fin.var_index = var_out;
          r_fin.negated   = neg_q;
        end else if (!seen_rd[neg_q]) begin
          seen_we         = 1'b1;
          fin_v           = 1'b1;
          r_fin.kind      = dcnf_pkg::KIND_INDEP;
          r_fin.var_index = var_out;
          r_fin.negated   = neg_q;
        end
      end
      mode_d = mode_a;

      case (mode_a)
        dcnf_pkg::M_TOP: begin
          if (eof_q) begin
            dsp_v      = 1'b1;
            r_dsp.kind = dcnf_pkg::KIND_DONE;
            mode_d     = dcnf_pkg::M_FIN;
          end else if (is_space) begin
            mode_d = dcnf_pkg::M_TOP;
          end else if (byte_q == dcnf_pkg::CH_P) begin
            mode_d = dcnf_pkg::M_SKIPLINE;
          end else if (byte_q == dcnf_pkg::CH_C) begin
            mode_d = dcnf_pkg::M_TAG;
            tag_d  = '0;
          end else begin
            // Any other byte opens a clause and is its first character.
            mode_d = dcnf_pkg::M_CLAUSE;
            nv_d   = '0;
            neg_d  = 1'b0;
            dig_d  = 1'b0;
            sgn_d  = 1'b0;
            if (byte_q == dcnf_pkg::CH_MINUS) begin
              neg_d = 1'b1;
              sgn_d = 1'b1;
            end else if (byte_q == dcnf_pkg::CH_PLUS) begin
              sgn_d = 1'b1;
            end else if (is_digit) begin
              nv_d  = VAR_BITS'(digit);
              dig_d = 1'b1;
            end else begin
              dsp_v            = 1'b1;
              r_dsp.kind       = dcnf_pkg::KIND_ERROR;
              r_dsp.error_line = line_d;
              mode_d           = dcnf_pkg::M_FIN;
            end
          end
        end
        dcnf_pkg::M_SKIPLINE: begin
          if (eof_q) begin
            dsp_v      = 1'b1;
            r_dsp.kind = dcnf_pkg::KIND_DONE;
            mode_d     = dcnf_pkg::M_FIN;
          end else if (is_nl) begin
            mode_d = dcnf_pkg::M_TOP;
          end
        end
        dcnf_pkg::M_TAG: begin
          if (eof_q || (byte_q != dcnf_pkg::tag_char(tag_q))) begin
            // A mismatch turns the line into a comment; the byte is seen there.
            mode_d = dcnf_pkg::M_SKIPLINE;
            if (eof_q) begin
              dsp_v      = 1'b1;
              r_dsp.kind = dcnf_pkg::KIND_DONE;
              mode_d     = dcnf_pkg::M_FIN;
            end else if (is_nl) begin
              mode_d = dcnf_pkg::M_TOP;
            end
          end else if (tag_q == dcnf_pkg::TAG_LAST) begin
            tag_d  = '0;
            mode_d = dcnf_pkg::M_SKIP1;
          end else begin
            tag_d = tag_q + 1'b1;
          end
        end
        dcnf_pkg::M_SKIP1: begin
          if (eof_q) begin
            dsp_v            = 1'b1;
            r_dsp.kind       = dcnf_pkg::KIND_ERROR;
            r_dsp.error_line = line_d;
            mode_d           = dcnf_pkg::M_FIN;
          end else begin
            mode_d = dcnf_pkg::M_INDEP;
            nv_d   = '0;
            neg_d  = 1'b0;
            dig_d  = 1'b0;
            sgn_d  = 1'b0;
          end
        end
        dcnf_pkg::M_CLAUSE, dcnf_pkg::M_INDEP: begin
          if (!fin_done && (dig_q || sgn_q) && !eof_q && is_digit) begin
            // Another digit of the number under way.
            nv_d  = sum[VAR_BITS-1:0];
            dig_d = 1'b1;
            sgn_d = 1'b0;
            if (sum_ovf) begin
              dsp_v            = 1'b1;
              r_dsp.kind       = dcnf_pkg::KIND_ERROR;
              r_dsp.error_line = line_d;
              mode_d           = dcnf_pkg::M_FIN;
            end
          end else if (!fin_done && sgn_q) begin
            dsp_v            = 1'b1;
            r_dsp.kind       = dcnf_pkg::KIND_ERROR;
            r_dsp.error_line = line_d;
            mode_d           = dcnf_pkg::M_FIN;
          end else if (eof_q) begin
            // The list or clause was never closed by a zero.
            dsp_v            = 1'b1;
            r_dsp.kind       = dcnf_pkg::KIND_ERROR;
            r_dsp.error_line = line_d;
            mode_d           = dcnf_pkg::M_FIN;
          end else if (is_space) begin
            mode_d = mode_a;
          end else if (byte_q == dcnf_pkg::CH_MINUS) begin
            neg_d = 1'b1;
            sgn_d = 1'b1;
          end else if (byte_q == dcnf_pkg::CH_PLUS) begin
            neg_d = 1'b0;
            sgn_d = 1'b1;
          end else if (is_digit) begin
            nv_d  = VAR_BITS'(digit);
            dig_d = 1'b1;
            sgn_d = 1'b0;
          end else begin
            dsp_v            = 1'b1;
            r_dsp.kind       = dcnf_pkg::KIND_ERROR;
            r_dsp.error_line = line_d;
            mode_d           = dcnf_pkg::M_FIN;
          end
        end
        dcnf_pkg::M_FIN: begin
          mode_d = dcnf_pkg::M_FIN;
        end
        default: begin
          mode_d = mode_a;
        end
      endcase
    end
  end

  // Pack the results of this byte in order and mark the final one.
  always_comb begin
    push.cnt          = 2'(fin_v) + 2'(dsp_v);
    push.item[0]      = fin_v ? r_fin : r_dsp;
    push.item[1]      = r_dsp;
    push.item[0].last = !(fin_v && dsp_v);
    push.item[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dcnf_pkg::M_TOP;
      nv_q   <= '0;
      neg_q  <= 1'b0;
      dig_q  <= 1'b0;
      sgn_q  <= 1'b0;
      tag_q  <= '0;
      line_q <= '0;
    end else begin
      mode_q <= mode_d;
      nv_q   <= nv_d;
      neg_q  <= neg_d;
      dig_q  <= dig_d;
      sgn_q  <= sgn_d;
      tag_q  <= tag_d;
      line_q <= line_d;
    end
  end

  // The bitmap is read at the next number value, so its entry is ready when the number ends.
  dcnf_seen_ram #(
    .VAR_BITS (VAR_BITS)
  ) u_seen_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (nv_d),
    .wr_en_i   (seen_we),
    .wr_addr_i (nv_q),
    .wr_data_i (seen_wd),
    .rd_data_o (seen_rd),
    .busy_o    (seen_busy)
  );

  // Result buffer and output channel.
  dcnf_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .head_o  (head),
    .valid_o (head_valid),
    .room_o  (room)
  );

  assign out_o.valid      = head_valid;
  assign out_o.kind       = head.kind;
  assign out_o.var_index  = head.var_index;
  assign out_o.negated    = head.negated;
  assign out_o.error_line = head.error_line;
  assign out_o.last       = head.last;

endmodule

FILE: design/dcnf_seen_ram.sv
// Bitmap of independent literals already reported, with a clearing pass after reset.
module dcnf_seen_ram #(
  parameter int unsigned VAR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [VAR_BITS-1:0] rd_addr_i,
  input  logic                wr_en_i,
  input  logic [VAR_BITS-1:0] wr_addr_i,
  input  logic [1:0]          wr_data_i,
  output logic [1:0]          rd_data_o,
  output logic                busy_o
);

  localparam int unsigned Depth = 2 ** VAR_BITS;

  logic [1:0]          mem [Depth];
  logic [1:0]          rd_data_q;
  logic [VAR_BITS-1:0] clr_addr_q, clr_addr_d;
  logic                busy_q, busy_d;
  logic                mem_we;
  logic [VAR_BITS-1:0] mem_waddr;
  logic [1:0]          mem_wdata;

  // The sweep writes zero to one entry per cycle until the last address.
  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == {VAR_BITS{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
    end
  end

  // The clearing pass owns the write port while it runs.
  assign mem_we    = busy_q || wr_en_i;
  assign mem_waddr = busy_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = busy_q ? 2'b00 : wr_data_i;

  // One write and one registered read per cycle; a read sees the old contents.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

FILE: design/dcnf_res_fifo.sv
// Four-entry result buffer that takes up to two items and gives one item per cycle while popped.
module dcnf_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dcnf_pkg::push_t push_i,
  input  logic            pop_i,
  output dcnf_pkg::res_t  head_o,
  output logic            valid_o,
  output logic            room_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dcnf_pkg::res_t  mem [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_next;
  logic            do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign wr_next = PtrW'(wr_q + 1'b1);

  // Pointer and fill count update.
  always_comb begin
    wr_d    = PtrW'(wr_q + push_i.cnt);
    rd_d    = do_pop ? PtrW'(rd_q + 1'b1) : rd_q;
    count_d = CntW'(count_q + CntW'(push_i.cnt) - CntW'(do_pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Entries are written at the tail and the one after it.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_q] <= push_i.item[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_next] <= push_i.item[1];
    end
  end

  assign head_o  = mem[rd_q];
  assign valid_o = (count_q != '0);
  // Room for a byte's worst case of two results.
  assign room_o  = (count_q <= CntW'(Depth - 2));

endmodule

FILE: tb/tb_dimacs_cnf_token_parser_core.sv
// Self-checking testbench of the DIMACS CNF token parser: byte stream in, tokens out.
module tb_dimacs_cnf_token_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dcnf_pkg::*;

  localparam int unsigned VAR_BITS = 16;
  localparam int unsigned VAR_MAX = (1 << VAR_BITS) - 1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT_TOKEN = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTED = 100;

  // Byte that is neither digit, sign nor whitespace.
  localparam logic [7:0] CH_BAD = 8'h78;
  localparam logic [7:0] CH_VT  = 8'd11;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [3:0][7:0] TAG_TEXT = {CH_D, CH_N, CH_I, CH_SPACE};
  localparam logic [5:0][7:0] BLANKS = {CH_SPACE, CH_CR, CH_FF, CH_VT, CH_NL, CH_TAB};

  // Tokens of the directed part that are plain to read off the text.
  localparam res_t NO_TOK = '0;
  localparam res_t TOK_INDEP_NEG1 = '{KIND_INDEP, 16'd1, 1'b1, 24'd0, 1'b1};
  localparam res_t TOK_LIT_MAX = '{KIND_LITERAL, 16'hFFFF, 1'b0, 24'd0, 1'b1};
  localparam res_t TOK_CLAUSE_END = '{KIND_CLAUSE_END, 16'd0, 1'b0, 24'd0, 1'b1};

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    res_t       tok;
  } dir_row_t;

  // Directed text: a p line with extreme bytes, an independent list with a repeat,
  // and a clause holding the largest variable.
  dir_row_t dir_rows [28] = '{
    '{CH_P, 1'b0, NO_TOK},
    '{CH_SPACE, 1'b0, NO_TOK},
    '{8'hFF, 1'b0, NO_TOK},
    '{8'h00, 1'b0, NO_TOK},
    '{CH_NL, 1'b0, NO_TOK},
    '{CH_C, 1'b0, NO_TOK},
    '{CH_SPACE, 1'b0, NO_TOK},
    '{CH_I, 1'b0, NO_TOK},
    '{CH_N, 1'b0, NO_TOK},
    '{CH_D, 1'b0, NO_TOK},
    '{CH_TAB, 1'b0, NO_TOK},
    '{CH_MINUS, 1'b0, NO_TOK},
    '{8'h31, 1'b0, NO_TOK},
    '{CH_SPACE, 1'b1, TOK_INDEP_NEG1},
    '{CH_MINUS, 1'b0, NO_TOK},
    '{8'h31, 1'b0, NO_TOK},
    '{CH_CR, 1'b0, NO_TOK},
    '{CH_ZERO, 1'b0, NO_TOK},
    '{CH_NL, 1'b0, NO_TOK},
    '{CH_PLUS, 1'b0, NO_TOK},
    '{8'h36, 1'b0, NO_TOK},
    '{8'h35, 1'b0, NO_TOK},
    '{8'h35, 1'b0, NO_TOK},
    '{8'h33, 1'b0, NO_TOK},
    '{8'h35, 1'b0, NO_TOK},
    '{CH_VT, 1'b1, TOK_LIT_MAX},
    '{CH_ZERO, 1'b0, NO_TOK},
    '{CH_SPACE, 1'b1, TOK_CLAUSE_END}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dcnf_in_if  in_if ();
  dcnf_out_if out_if ();

  dimacs_cnf_token_parser_core #(
    .VAR_BITS(VAR_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Lexer state kept by the testbench.
  mode_e       lx_mode = M_TOP;
  int unsigned num_val = 0;
  logic        num_neg = 1'b0;
  logic        has_digits = 1'b0;
  logic        sign_wait = 1'b0;
  int          tag_pos = 0;
  logic [LINE_W-1:0] line_cnt = '0;
  bit          indep_seen [0:(1 << (VAR_BITS + 1)) - 1];

  // Tokens caused by the byte being handled, and all tokens still awaited.
  res_t step_tok [2];
  int   step_cnt;
  res_t token_q [$];

  int  mismatch_cnt = 0;
  int  bytes_sent = 0;
  int  cycle_cnt = 0;
  int  tx_left = 0;
  bit  tx_quiet = 1'b0;

  function automatic void add_token(kind_e k, logic [VIDX_W-1:0] v, logic n,
                                    logic [LINE_W-1:0] ln);
    if (step_cnt < 2) begin
      step_tok[step_cnt] = '{k, v, n, ln, 1'b0};
      step_cnt++;
    end
  endfunction

  function automatic void flag_error();
    add_token(KIND_ERROR, '0, 1'b0, line_cnt);
    lx_mode = M_FIN;
  endfunction

  function automatic void clear_number();
    num_val = 0;
    num_neg = 1'b0;
    has_digits = 1'b0;
    sign_wait = 1'b0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // A digit extends the number; a variable beyond range is an error at once.
  function automatic void add_digit(logic [7:0] c);
    num_val = num_val * 10 + (c - CH_ZERO);
    has_digits = 1'b1;
    sign_wait = 1'b0;
    if (num_val > VAR_MAX) flag_error();
  endfunction

  // Work out the tokens of one byte. A byte that ends a number is handled again
  // in the mode that follows, so it may cause two tokens.
  function automatic void lex_byte(logic [7:0] ch, logic eof);
    bit          again;
    int          guard;
    int unsigned done_val;
    logic        done_neg;
    step_cnt = 0;
    if (!eof && ch == CH_NL && line_cnt != LINE_MAX) line_cnt++;
    again = 1'b1;
    guard = 0;
    while (again && guard < 4) begin
      again = 1'b0;
      guard++;
      case (lx_mode)
        M_TOP: begin
          if (eof) begin
            add_token(KIND_DONE, '0, 1'b0, '0);
            lx_mode = M_FIN;
          end else if (is_blank(ch)) begin
          end else if (ch == CH_P) begin
            lx_mode = M_SKIPLINE;
          end else if (ch == CH_C) begin
            lx_mode = M_TAG;
            tag_pos = 0;
          end else begin
            lx_mode = M_CLAUSE;
            clear_number();
            again = 1'b1;
          end
        end
        M_SKIPLINE: begin
          if (eof) begin
            add_token(KIND_DONE, '0, 1'b0, '0);
            lx_mode = M_FIN;
          end else if (ch == CH_NL) begin
            lx_mode = M_TOP;
          end
        end
        M_TAG: begin
          if (eof || ch != TAG_TEXT[tag_pos]) begin
            lx_mode = M_SKIPLINE;
            again = 1'b1;
          end else begin
            tag_pos++;
            if (tag_pos == 4) begin
              tag_pos = 0;
              lx_mode = M_SKIP1;
            end
          end
        end
        M_SKIP1: begin
          if (eof) begin
            flag_error();
          end else begin
            lx_mode = M_INDEP;
            clear_number();
          end
        end
        M_CLAUSE, M_INDEP: begin
          if (has_digits) begin
            if (!eof && is_digit(ch)) begin
              add_digit(ch);
            end else begin
              // The number ends here: a zero closes the list.
              done_val = num_val;
              done_neg = num_neg;
              clear_number();
              if (done_val == 0) begin
                if (lx_mode == M_CLAUSE) add_token(KIND_CLAUSE_END, '0, 1'b0, '0);
                lx_mode = M_TOP;
              end else if (lx_mode == M_CLAUSE) begin
                add_token(KIND_LITERAL, done_val[VIDX_W-1:0], done_neg, '0);
              end else if (!indep_seen[{done_val[VIDX_W-1:0], done_neg}]) begin
                indep_seen[{done_val[VIDX_W-1:0], done_neg}] = 1'b1;
                add_token(KIND_INDEP, done_val[VIDX_W-1:0], done_neg, '0);
              end
              again = 1'b1;
            end
          end else if (sign_wait) begin
            if (!eof && is_digit(ch)) add_digit(ch);
            else flag_error();
          end else if (eof) begin
            flag_error();
          end else if (is_blank(ch)) begin
          end else if (ch == CH_MINUS) begin
            num_neg = 1'b1;
            sign_wait = 1'b1;
          end else if (ch == CH_PLUS) begin
            num_neg = 1'b0;
            sign_wait = 1'b1;
          end else if (is_digit(ch)) begin
            add_digit(ch);
          end else begin
            flag_error();
          end
        end
        default: begin
        end
      endcase
    end
    if (step_cnt > 0) step_tok[step_cnt-1].last = 1'b1;
  endfunction

  // Idle cycles before the next item; some stretches run without any idling.
  function automatic int draw_wait(inout int left, inout bit quiet);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Offer one byte, wait for it to be taken, then record the tokens it causes.
  task automatic send_byte(input logic [7:0] ch, input logic eof = 1'b0,
                           input logic typed = 1'b0, input res_t tok = '0);
    int gap;
    gap = draw_wait(tx_left, tx_quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.byte_value <= ch;
    in_if.end_of_input <= eof;
    do @(posedge clk_i); while (!in_if.ready);
    lex_byte(ch, eof);
    if (typed) begin
      token_q = {token_q, tok};
    end else begin
      for (int i = 0; i < step_cnt; i++) token_q = {token_q, step_tok[i]};
    end
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_blank();
    send_byte(BLANKS[$urandom_range(0, 5)]);
  endtask

  // Signed number, mostly small so that repeats occur, now and then with a leading zero.
  task automatic send_literal(input int unsigned max_v, input bit force_neg);
    int unsigned v;
    v = ($urandom_range(0, 15) == 0) ? $urandom_range(1, VAR_MAX) : $urandom_range(1, max_v);
    if (force_neg || $urandom_range(0, 2) == 0) send_byte(CH_MINUS);
    else if ($urandom_range(0, 7) == 0) send_byte(CH_PLUS);
    if ($urandom_range(0, 9) == 0) send_byte(CH_ZERO);
    send_text($sformatf("%0d", v));
  endtask

  // Literals closed by a zero; a minus sign may follow a number with no space.
  task automatic send_list(input int unsigned max_v);
    int n;
    bit glued;
    n = $urandom_range(0, 6);
    glued = 1'b0;
    repeat (n) begin
      send_literal(max_v, glued);
      glued = ($urandom_range(0, 5) == 0);
      if (!glued) begin
        send_blank();
        if ($urandom_range(0, 3) == 0) send_blank();
      end
    end
    case (glued ? 2 : $urandom_range(0, 3))
      0: send_text("0");
      1: send_text("00");
      2: send_text("-0");
      default: send_text("+0");
    endcase
    send_blank();
  endtask

  // Skipped line; after a c the tag may match in part before it breaks off.
  task automatic send_skipped_line(input logic [7:0] lead);
    int         k;
    int         len;
    logic [7:0] b;
    send_byte(lead);
    if (lead == CH_C) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) send_byte(TAG_TEXT[i]);
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL || b == TAG_TEXT[k]);
      send_byte(b);
    end
    len = $urandom_range(0, 10);
    repeat (len) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
      send_byte(b);
    end
    send_byte(CH_NL);
  endtask

  // Stimulus: directed text, random well-formed text, then one way of ending.
  initial begin
    int pick;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.byte_value <= '0;
    in_if.end_of_input <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, 1'b0, dir_rows[i].typed, dir_rows[i].tok);

    while (bytes_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        send_list(40);
      end else if (pick < 13) begin
        send_text("c ind");
        send_byte(8'($urandom_range(0, 255)));
        send_list(20);
      end else if (pick < 17) begin
        send_skipped_line(CH_C);
      end else if (pick < 18) begin
        send_skipped_line(CH_P);
      end else begin
        send_blank();
      end
    end

    // The stream ends in a done or in an error.
    case ($urandom_range(0, 9))
      0: send_byte(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        send_text("c i");
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        send_text("p cnf");
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      3: begin
        send_text("c ind");
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      4: begin
        send_literal(50, 1'b0);
        send_blank();
        send_literal(50, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      5: begin
        send_literal(50, 1'b0);
        send_byte(CH_BAD);
      end
      6: send_text($sformatf("%0d", $urandom_range(VAR_MAX + 1, 999999)));
      7: begin
        send_byte(CH_MINUS);
        send_blank();
      end
      8: begin
        send_literal(50, 1'b0);
        send_blank();
        send_byte(CH_ZERO);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: send_byte(CH_BAD);
    endcase

    // Once finished the block takes further bytes without any token.
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_if.valid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Token receiver: random stalls, and one long hold-off that backs up the input.
  initial begin
    int   stall;
    int   rx_left;
    bit   rx_quiet;
    int   tok_seen;
    bit   held;
    res_t want;
    rx_left = 0;
    rx_quiet = 1'b0;
    tok_seen = 0;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = draw_wait(rx_left, rx_quiet);
      if (!held && tok_seen == HOLD_AT_TOKEN) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      tok_seen++;
      if (token_q.size() == 0) begin
        report_mismatch($sformatf("token with none expected: kind %0d var %0d",
                                  out_if.kind, out_if.var_index));
      end else begin
        want = token_q.pop_front();
        if (out_if.kind !== want.kind || out_if.var_index !== want.var_index ||
            out_if.negated !== want.negated || out_if.error_line !== want.error_line ||
            out_if.last !== want.last) begin
          report_mismatch($sformatf(
            "got kind %0d var %0d neg %0d line %0d last %0d, want %0d %0d %0d %0d %0d",
            out_if.kind, out_if.var_index, out_if.negated, out_if.error_line, out_if.last,
            want.kind, want.var_index, want.negated, want.error_line, want.last));
        end
      end
    end
  end

  // Watchdog, allowing for the bitmap sweep after reset.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
